// File: rtl/mf3_pkg.sv
package mf3_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   // column address, width value (up to MAX_WIDTH itself) and row counter widths
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic       pad;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_data_type;

   typedef struct packed {
      logic [7:0] med_red;
      logic [7:0] med_green;
      logic [7:0] med_blue;
      logic [7:0] centre_alpha;
      logic       end_of_frame;
   } rsp_data_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // one line store entry: the two rows above the incoming one at a column
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_type;

   // per-word control decided at accept time, carried with the word
   typedef struct packed {
      logic flushing;
      logic emit;
      logic first_row;
      logic last_row;
      logic sel0_mid;
      logic sel2_mid;
      logic eof;
   } ctrl_type;

endpackage

// File: rtl/mf3_line_store.sv
module mf3_line_store import mf3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  line_type         wr_data,
   output line_type         rd_data
);

   line_type mem [MAX_WIDTH];

   line_type rd_ff;
   line_type byp_data_ff;
   logic     byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // a read that meets a write to the same column takes the new data
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

// File: rtl/mf3_window.sv
module mf3_window import mf3_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           shift,
   input  logic           load,
   input  ctrl_type       ctrl,
   input  pixel_type      top_in,
   input  pixel_type      mid_in,
   input  pixel_type      bot_in,
   output pixel_type [8:0] nb,
   output logic           eof
);

   // index col*3+row, column 0 oldest, row 0 top
   pixel_type [8:0] win_ff;
   pixel_type [8:0] win_in;
   pixel_type [8:0] nb_ff;
   pixel_type [8:0] nb_in;
   logic            eof_ff;

   pixel_type [2:0] col_a;
   pixel_type [2:0] col_b;
   pixel_type [2:0] col_c;
   pixel_type [2:0] pick [3];

   always_comb begin
      win_in[5:0] = win_ff[8:3];
      win_in[6]   = top_in;
      win_in[7]   = mid_in;
      win_in[8]   = bot_in;
   end

   // clamp columns at the left and right edges and rows at the top and bottom edges
   always_comb begin
      col_a   = win_in[2:0];
      col_b   = win_in[5:3];
      col_c   = win_in[8:6];
      pick[0] = ctrl.sel0_mid ? col_b : col_a;
      pick[1] = col_b;
      pick[2] = ctrl.sel2_mid ? col_b : col_c;
      for (int c = 0; c < 3; c++) begin
         nb_in[c]     = ctrl.first_row ? pick[c][1] : pick[c][0];
         nb_in[3 + c] = pick[c][1];
         nb_in[6 + c] = ctrl.last_row ? pick[c][1] : pick[c][2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (shift) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nb_ff  <= nb_in;
         eof_ff <= ctrl.eof;
      end
   end

   assign nb  = nb_ff;
   assign eof = eof_ff;

endmodule

// File: rtl/mf3_median.sv
module mf3_median import mf3_pkg::*; (
   input  logic            clock,
   input  logic            sort_load,
   input  logic            out_load,
   input  pixel_type [8:0] nb,
   input  logic            eof,
   output rsp_data_type    rsp_data
);

   logic [7:0]  val [3][9];
   logic [23:0] tri_in [3][3];
   logic [23:0] tri_ff [3][3];
   logic [7:0]  alpha_ff;
   logic        eof_ff;
   logic [7:0]  med [3];
   rsp_data_type out_ff;

   // returns {hi, mid, lo}
   function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] t;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      t  = (hi < c) ? hi : c;
      hi = (hi < c) ? c : hi;
      return (lo < t) ? {hi, t, lo} : {hi, lo, t};
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [23:0] s;
      s = sort3(a, b, c);
      return s[15:8];
   endfunction

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         val[0][i] = nb[i].red;
         val[1][i] = nb[i].green;
         val[2][i] = nb[i].blue;
      end
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 3; k++) begin
            tri_in[ch][k] = sort3(val[ch][3*k], val[ch][3*k + 1], val[ch][3*k + 2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sort_load) begin
         tri_ff   <= tri_in;
         alpha_ff <= nb[4].alpha;
         eof_ff   <= eof;
      end
   end

   // median of nine = med3(max of lows, med of mids, min of highs)
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         med[ch] = med3(max3(tri_ff[ch][0][7:0], tri_ff[ch][1][7:0], tri_ff[ch][2][7:0]),
                        med3(tri_ff[ch][0][15:8], tri_ff[ch][1][15:8], tri_ff[ch][2][15:8]),
                        min3(tri_ff[ch][0][23:16], tri_ff[ch][1][23:16],
                             tri_ff[ch][2][23:16]));
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff.med_red      <= med[0];
         out_ff.med_green    <= med[1];
         out_ff.med_blue     <= med[2];
         out_ff.centre_alpha <= alpha_ff;
         out_ff.end_of_frame <= eof_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

// File: rtl/median_filter_3x3_rgba_core.sv
// Path: after the accept of the word that completes its neighborhood (image_width + 1 words
//   after its centre pixel), a result is registered in stage A, the window, sort and output.
// Throughput: one word per cycle unless rsp_stall fills the pipeline; line store entries are
//   read at accept and written back as the word leaves stage A; the median network has two stages.
// Reset (synchronous): counters, window, pipeline valids cleared, size back to 640 x 480;
//   the line stores are not cleared.
module median_filter_3x3_rgba_core import mf3_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic [WID_W-1:0]        eff_w;
   logic [ROW_W-1:0]        eff_h;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic             a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic [COL_W-1:0] a_col_ff;
   pixel_type        a_pix_ff;
   ctrl_type         a_ctrl_ff;

   ctrl_type  ctrl_in;
   pixel_type pix_in;
   logic      flushing, col_nz, row_end, out_col_end, out_row_end;
   logic      req_fire, take;
   logic      ready_b, ready_c, ready_d, a_move;

   line_type  lb_rd;
   line_type  lb_wr;
   pixel_type bot_in;
   pixel_type [8:0] nb;
   logic      nb_eof;

   // clamp register values to the supported range
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = ROW_W'(height_ff);
      end
   end

   // pipeline flow: a stage moves when the one after it is empty or moving
   assign ready_d   = !d_valid_ff || !rsp_stall;
   assign ready_c   = !c_valid_ff || ready_d;
   assign ready_b   = !b_valid_ff || ready_c;
   assign a_move    = a_valid_ff && ready_b;
   assign req_stall = a_valid_ff && !ready_b;
   assign req_fire  = req_valid && !req_stall;

   // decide per word at accept time
   always_comb begin
      flushing    = in_row_ff >= eff_h;
      col_nz      = in_col_ff != '0;
      row_end     = (WID_W'(in_col_ff) + WID_W'(1)) >= eff_w;
      out_col_end = (WID_W'(out_col_ff) + WID_W'(1)) >= eff_w;
      out_row_end = (out_row_ff + ROW_W'(1)) >= eff_h;

      ctrl_in.flushing  = flushing;
      ctrl_in.emit      = (in_row_ff >= ROW_W'(2)) || ((in_row_ff == ROW_W'(1)) && col_nz);
      ctrl_in.first_row = col_nz ? (in_row_ff == ROW_W'(1)) : (in_row_ff == ROW_W'(2));
      ctrl_in.last_row  = col_nz ? (in_row_ff >= eff_h) : (in_row_ff >= (eff_h + ROW_W'(1)));
      ctrl_in.sel0_mid  = (in_col_ff == COL_W'(1)) || (!col_nz && (eff_w == WID_W'(1)));
      ctrl_in.sel2_mid  = !col_nz;
      ctrl_in.eof       = out_row_end && out_col_end;

      pix_in.red   = req_data.red;
      pix_in.green = req_data.green;
      pix_in.blue  = req_data.blue;
      pix_in.alpha = req_data.alpha;

      // drop pad words that arrive before the frame is complete
      take = req_fire && !(req_data.pad && !flushing);
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (take) begin
         if (ctrl_in.emit && ctrl_in.eof) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (row_end) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (ctrl_in.emit) begin
               if (out_col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[CFG_WIDTH_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[CFG_HEIGHT_W-1:0];
            end
         endcase
         // restart the frame
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            a_valid_ff <= 1'b1;
         end else if (a_move) begin
            a_valid_ff <= 1'b0;
         end
         if (ready_b) begin
            b_valid_ff <= a_valid_ff && a_ctrl_ff.emit;
         end
         if (ready_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (ready_d) begin
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_col_ff  <= in_col_ff;
         a_pix_ff  <= pix_in;
         a_ctrl_ff <= ctrl_in;
      end
   end

   // shift the stored rows up by one at this column
   assign lb_wr.upper  = lb_rd.middle;
   assign lb_wr.middle = a_pix_ff;
   assign bot_in       = a_ctrl_ff.flushing ? '0 : a_pix_ff;

   mf3_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .wr_en   (a_move && !a_ctrl_ff.flushing),
      .wr_addr (a_col_ff),
      .wr_data (lb_wr),
      .rd_data (lb_rd)
   );

   mf3_window u_window (
      .clock  (clock),
      .reset  (reset),
      .shift  (a_move),
      .load   (a_move && a_ctrl_ff.emit),
      .ctrl   (a_ctrl_ff),
      .top_in (lb_rd.upper),
      .mid_in (lb_rd.middle),
      .bot_in (bot_in),
      .nb     (nb),
      .eof    (nb_eof)
   );

   mf3_median u_median (
      .clock     (clock),
      .sort_load (b_valid_ff && ready_c),
      .out_load  (c_valid_ff && ready_d),
      .nb        (nb),
      .eof       (nb_eof),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid = d_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && c_valid_ff && d_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline has a free stage");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.pad && !flushing && !csr_write)
      |=> ($stable(in_col_ff) && $stable(in_row_ff) && $stable(out_col_ff)
           && $stable(out_row_ff)))
      else $error("early pad word changed the frame position");

   assert property (@(posedge clock) disable iff (reset)
      WID_W'(in_col_ff) < eff_w)
      else $error("input column ran past the row width");

   assert property (@(posedge clock) disable iff (reset)
      (WID_W'(out_col_ff) < eff_w) && (out_row_ff < eff_h))
      else $error("output position left the frame");

endmodule
